[rtl/core/swgp_pkg.sv]
// ----------------------------------------------------------------------------
// swgp_pkg
// Shared constants, codes and helpers for the grouped-probe hash map.
// ----------------------------------------------------------------------------
package swgp_pkg;

    localparam int unsigned DEF_CAPACITY        = 1024;
    localparam int unsigned DEF_SLOTS_PER_GROUP = 32;
    localparam int unsigned KEY_BYTES           = 8;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned TAG_W   = 7;
    localparam int unsigned IN_W    = 104;
    localparam int unsigned OUT_W   = 40;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [7:0]  CTRL_EMPTY = 8'h80;
    localparam logic [7:0]  CTRL_TOMB  = 8'hFE;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // One FNV-1a round; the prime 2^40 + 0x1b3 is applied as shifts and adds.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

[rtl/core/swiss_group_probe_hash_map.sv]
// ----------------------------------------------------------------------------
// swiss_group_probe_hash_map
// Fixed-capacity hash map with grouped control-byte probing.
// ----------------------------------------------------------------------------
// One request (insert, lookup, remove) is taken at a time. The key is hashed
// one byte per cycle, then control rows of SLOTS_PER_GROUP bytes are read
// from a row-wide memory, through S_FRD, S_FROW and S_FPICK for each group on
// the search pass and S_PRD and S_PROW for each group on the free-slot pass,
// and each tag candidate is read and compared on the single slot memory port.
// An unused opcode skips hashing and probing. Inserts of new keys add the
// free-slot pass, and long probe chains add further groups searched, groups
// scanned for a free slot and candidates compared.
// After reset the block clears the control memory, one row per cycle, all
// CAPACITY/SLOTS_PER_GROUP rows (32 at the defaults), before it accepts the
// first item. A finished result waits in an output register so the next item
// may be accepted meanwhile.
// ----------------------------------------------------------------------------
module swiss_group_probe_hash_map import swgp_pkg::*; #(
    parameter int unsigned CAPACITY        = DEF_CAPACITY,
    parameter int unsigned SLOTS_PER_GROUP = DEF_SLOTS_PER_GROUP
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[1:0], key_bytes[65:2], key_length[69:66], new_value[101:70], zero
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status[1:0], found_value[33:2], zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int unsigned NUM_GROUPS = CAPACITY / SLOTS_PER_GROUP;
    localparam int unsigned CAP_W      = $clog2(CAPACITY);
    localparam int unsigned GS_W       = $clog2(SLOTS_PER_GROUP);
    localparam int unsigned G_W        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int unsigned ROW_W      = SLOTS_PER_GROUP * 8;
    localparam int unsigned SLOT_W     = KEY_W + LEN_W + VAL_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_FRD, S_FROW, S_FPICK, S_FCMP,
        S_PRD, S_PROW, S_RESP
    } t_state;

    t_state           r_state;
    logic [G_W-1:0]   r_grp, r_home, r_gcnt;
    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [LEN_W-1:0] r_len;
    logic [VAL_W-1:0] r_val;
    logic [TAG_W-1:0] r_tag;
    logic [SLOTS_PER_GROUP-1:0] r_mask;
    logic             r_has_empty;
    logic [GS_W-1:0]  r_slot;
    logic [1:0]       r_status;
    logic [VAL_W-1:0] r_found;
    logic             r_mvalid;
    logic [OUT_W-1:0] r_mdata;

    // Memories
    logic [ROW_W-1:0]  ctrl_mem [NUM_GROUPS];
    logic [SLOT_W-1:0] slot_mem [CAPACITY];
    logic [ROW_W-1:0]  r_ctrl_q;
    logic [SLOT_W-1:0] r_slot_q;
    logic              ctrl_re, ctrl_we, slot_re, slot_we;
    logic [ROW_W-1:0]  ctrl_wd;
    logic [CAP_W-1:0]  slot_a;
    logic [GS_W-1:0]   slot_idx;

    // Input unpacking and key preparation
    logic [1:0]       in_op;
    logic [KEY_W-1:0] in_key_raw, in_key;
    logic [LEN_W-1:0] in_len_raw, in_len;
    logic [VAL_W-1:0] in_val;
    logic             accept;

    assign in_op      = s_axis_tdata[1:0];
    assign in_key_raw = s_axis_tdata[65:2];
    assign in_len_raw = s_axis_tdata[69:66];
    assign in_val     = s_axis_tdata[101:70];
    assign in_len     = (in_len_raw > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_len_raw;
    assign in_key     = (in_len >= LEN_W'(8)) ? in_key_raw
                      : in_key_raw & ((64'd1 << {in_len, 3'd0}) - 64'd1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    logic        h_done;
    logic [63:0] h_val;

    swgp_fnv u_fnv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (in_key),
        .i_len   (in_len),
        .o_done  (h_done),
        .o_hash  (h_val)
    );

    logic [63:0] home64;
    assign home64 = (h_val >> (TAG_W + GS_W)) % NUM_GROUPS;

    // Row decode
    logic [SLOTS_PER_GROUP-1:0] tag_hit, empty_hit, tomb_hit;
    always_comb begin
        for (int i = 0; i < SLOTS_PER_GROUP; i++) begin
            tag_hit[i]   = (r_ctrl_q[i*8 +: 8] == {1'b0, r_tag});
            empty_hit[i] = (r_ctrl_q[i*8 +: 8] == CTRL_EMPTY);
            tomb_hit[i]  = (r_ctrl_q[i*8 +: 8] == CTRL_TOMB);
        end
    end

    function automatic logic [GS_W-1:0] lowest(input logic [SLOTS_PER_GROUP-1:0] v);
        logic [GS_W-1:0] r;
        r = '0;
        for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--)
            if (v[i]) r = GS_W'(i);
        return r;
    endfunction

    logic [GS_W-1:0] pick_idx, empty_idx, tomb_idx, free_idx;
    logic            key_match, last_grp;
    logic [G_W-1:0]  next_grp;

    assign pick_idx  = lowest(r_mask);
    assign empty_idx = lowest(empty_hit);
    assign tomb_idx  = lowest(tomb_hit);
    assign free_idx  = (|empty_hit) ? empty_idx : tomb_idx;
    assign key_match = (r_slot_q == {r_key, r_len, r_slot_q[VAL_W-1:0]});
    assign last_grp  = (r_gcnt == G_W'(NUM_GROUPS - 1));
    assign next_grp  = (r_grp == G_W'(NUM_GROUPS - 1)) ? '0 : r_grp + 1'b1;

    // Memory control
    always_comb begin
        ctrl_re  = (r_state == S_FRD) || (r_state == S_PRD);
        ctrl_we  = 1'b0;
        ctrl_wd  = r_ctrl_q;
        slot_re  = 1'b0;
        slot_we  = 1'b0;
        slot_idx = r_slot;
        unique case (r_state)
            S_CLEAR: begin
                ctrl_we = 1'b1;
                ctrl_wd = {SLOTS_PER_GROUP{CTRL_EMPTY}};
            end
            S_FPICK: begin
                slot_idx = pick_idx;
                slot_re  = (r_mask != '0);
            end
            S_FCMP: begin
                if (key_match && r_op == OP_INSERT) slot_we = 1'b1;
                if (key_match && r_op == OP_REMOVE) begin
                    ctrl_we = 1'b1;
                    ctrl_wd[r_slot*8 +: 8] = CTRL_TOMB;
                end
            end
            S_PROW: begin
                slot_idx = free_idx;
                if (|(empty_hit | tomb_hit)) begin
                    slot_we = 1'b1;
                    ctrl_we = 1'b1;
                    ctrl_wd[free_idx*8 +: 8] = {1'b0, r_tag};
                end
            end
            default: ;
        endcase
    end

    assign slot_a = CAP_W'({r_grp, slot_idx});

    always_ff @(posedge i_clk) begin
        if (ctrl_we) ctrl_mem[r_grp] <= ctrl_wd;
        if (ctrl_re) r_ctrl_q <= ctrl_mem[r_grp];
        if (slot_we) slot_mem[slot_a] <= {r_key, r_len, r_val};
        if (slot_re) r_slot_q <= slot_mem[slot_a];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_grp    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            // in S_RESP the output register is free, being drained or still waiting; valid is set in each case
            if (r_state == S_RESP) r_mvalid <= 1'b1;
            else if (m_axis_tready) r_mvalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_grp <= next_grp;
                    if (r_grp == G_W'(NUM_GROUPS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= in_op;
                        r_key    <= in_key;
                        r_len    <= in_len;
                        r_val    <= in_val;
                        r_status <= ST_MISS;
                        r_found  <= '0;
                        r_state  <= (in_op == OP_INSERT || in_op == OP_LOOKUP ||
                                     in_op == OP_REMOVE) ? S_HASH : S_RESP;
                    end
                end
                S_HASH: begin
                    if (h_done) begin
                        r_tag   <= h_val[TAG_W-1:0];
                        r_home  <= G_W'(home64);
                        r_grp   <= G_W'(home64);
                        r_gcnt  <= '0;
                        r_state <= S_FRD;
                    end
                end
                S_FRD: r_state <= S_FROW;
                S_FROW: begin
                    r_mask      <= tag_hit;
                    r_has_empty <= |empty_hit;
                    r_state     <= S_FPICK;
                end
                S_FPICK: begin
                    if (r_mask != '0) begin
                        r_slot <= pick_idx;
                        r_mask[pick_idx] <= 1'b0;
                        r_state <= S_FCMP;
                    end else if (r_has_empty || last_grp) begin
                        // key absent
                        if (r_op == OP_INSERT) begin
                            r_grp   <= r_home;
                            r_gcnt  <= '0;
                            r_state <= S_PRD;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_grp   <= next_grp;
                        r_gcnt  <= r_gcnt + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_FCMP: begin
                    if (key_match) begin
                        r_status <= ST_OK;
                        if (r_op != OP_INSERT) r_found <= r_slot_q[VAL_W-1:0];
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_FPICK;
                    end
                end
                S_PRD: r_state <= S_PROW;
                S_PROW: begin
                    if (|(empty_hit | tomb_hit)) begin
                        r_status <= ST_OK;
                        r_state  <= S_RESP;
                    end else if (last_grp) begin
                        r_status <= ST_FULL;
                        r_state  <= S_RESP;
                    end else begin
                        r_grp   <= next_grp;
                        r_gcnt  <= r_gcnt + 1'b1;
                        r_state <= S_PRD;
                    end
                end
                S_RESP: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mdata  <= {6'd0, r_found, r_status};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

endmodule

[rtl/core/swgp_fnv.sv]
// ----------------------------------------------------------------------------
// swgp_fnv
// Byte-serial FNV-1a 64 hash, one key byte per cycle.
// ----------------------------------------------------------------------------
module swgp_fnv import swgp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_done,
    output logic [63:0]      o_hash
);

    logic             r_busy;
    logic [LEN_W-1:0] r_cnt;
    logic [63:0]      r_h;
    logic [KEY_W-1:0] r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_len;
            r_h    <= FNV_BASIS;
            r_key  <= i_key;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_h   <= fnv_step(r_h, r_key[7:0]);
                r_key <= r_key >> 8;
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == '0) && !i_start;
    assign o_hash = r_h;

endmodule

[rtl/core/swgp_checker.sv]
// ----------------------------------------------------------------------------
// swgp_checker
// Port-level checks for the hash map, bound to the top level.
// ----------------------------------------------------------------------------
module swgp_checker import swgp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // no item taken right after reset; only the start of the clear is checked
    a_clear: assert property (@(posedge i_clk) $past(!i_rst_n) |-> !s_axis_tready)
        else $error("ready during clear");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_MISS ||
                           m_axis_tdata[1:0] == ST_FULL))
        else $error("bad status");

    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[33:2] == '0))
        else $error("value on miss");

    // a result does not appear directly after its item is accepted with the output empty
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result too early");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");

endmodule

bind swiss_group_probe_hash_map swgp_checker u_swgp_checker (.*);
